@@ src/pts_pkg.sv @@
// Package: shared types, constants and codes of the packet traffic statistics block.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;
  localparam int PortEntries = 64;
  localparam int IdxW = $clog2(PortEntries);
  localparam int UsedW = IdxW + 1;
  localparam int HdrBytes = 58;
  localparam int HposW = 6;
  localparam int NumCounters = 14;

  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_STAT = 2'd1;
  localparam logic [1:0] FUNC_UDP = 2'd2;
  localparam logic [1:0] FUNC_TCP = 2'd3;

  localparam logic [1:0] REG_DNS = 2'd0;
  localparam logic [1:0] REG_HTTP = 2'd1;
  localparam logic [1:0] REG_HTTPS = 2'd2;

  localparam logic [3:0] C_FRAMES = 4'd0;
  localparam logic [3:0] C_ARP_REQ = 4'd1;
  localparam logic [3:0] C_ARP_REP = 4'd2;
  localparam logic [3:0] C_IPV4 = 4'd3;
  localparam logic [3:0] C_ICMP_REP = 4'd4;
  localparam logic [3:0] C_ICMP_REQ = 4'd5;
  localparam logic [3:0] C_IPV6 = 4'd6;
  localparam logic [3:0] C_ICMP6_REP = 4'd7;
  localparam logic [3:0] C_ICMP6_REQ = 4'd8;
  localparam logic [3:0] C_UDP = 4'd9;
  localparam logic [3:0] C_TCP = 4'd10;
  localparam logic [3:0] C_HTTP = 4'd11;
  localparam logic [3:0] C_DNS = 4'd12;
  localparam logic [3:0] C_HTTPS = 4'd13;

  localparam logic [4:0] SEL_MIN = 5'd14;
  localparam logic [4:0] SEL_MAX = 5'd15;
  localparam logic [4:0] SEL_SUM = 5'd16;

  localparam logic [16:0] SizeReset = 17'd1518;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_byte;   // write the byte into the header store
    logic classify;     // evaluate the header and bump frame counters
    logic scan_start;   // start a port table search
    logic scan_step;    // compare one table entry
    logic port_sel;     // 0 source port, 1 destination port
    logic clear_hdr;    // clear the header store and position
    logic read_req;     // register a read result
  } pts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_ports;    // classified frame is UDP or TCP
    logic scan_done;    // search finished this cycle
  } pts_stat_t;
endpackage
`default_nettype wire

@@ src/pts_if.sv @@
// Interfaces: valid/ready channels for items, results and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface pts_in_if;
  logic valid;
  logic ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic last_byte;
  logic [4:0] stat_select;
  logic [5:0] entry_index;
  modport source (output valid, func, data_byte, last_byte, stat_select, entry_index,
                  input ready);
  modport sink (input valid, func, data_byte, last_byte, stat_select, entry_index,
                output ready);
endinterface

interface pts_out_if;
  logic valid;
  logic ready;
  logic [47:0] stat_value;
  logic [15:0] entry_port;
  logic [31:0] entry_count;
  logic entry_valid;
  modport source (output valid, stat_value, entry_port, entry_count, entry_valid,
                  input ready);
  modport sink (input valid, stat_value, entry_port, entry_count, entry_valid,
                output ready);
endinterface

interface pts_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/pts_ctrl.sv @@
// Controller: sequences byte capture, frame classification and port table searches.
`timescale 1ns / 1ps
`default_nettype none
module pts_ctrl
  import pts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic [1:0] in_func,
  input  wire logic in_last,
  input  wire logic out_busy,
  input  wire pts_stat_t stat,
  output logic in_ready,
  output pts_cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLASS = 4'b0010,
    S_SRC   = 4'b0100,
    S_DST   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic started;

  // Items are taken only in idle and only while no result is pending in the output register.
  assign in_ready = (state == S_IDLE) && !out_busy;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_BYTE) begin
            cmd.store_byte = 1'b1;
            if (in_last) state_next = S_CLASS;
          end else begin
            cmd.read_req = 1'b1;
          end
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        if (stat.has_ports) begin
          cmd.scan_start = 1'b1;
          state_next = S_SRC;
        end else begin
          cmd.clear_hdr = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SRC: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          cmd.scan_start = 1'b1;
          state_next = S_DST;
        end
      end
      S_DST: begin
        cmd.scan_step = 1'b1;
        cmd.port_sel = 1'b1;
        if (stat.scan_done) begin
          cmd.clear_hdr = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      started <= 1'b0;
    end else begin
      state <= state_next;
      started <= 1'b1;
    end
  end

  // A search never starts outside the classify or source steps.
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> (state == S_CLASS || state == S_SRC))
    else $error("search started in wrong state");
  // Items are never taken while a frame is being finished.
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("ready while busy");
  // The last byte of a frame leads to the classify step.
  a_last: assert property (@(posedge clk) disable iff (rst)
    (started && in_fire && in_func == FUNC_BYTE && in_last) |=> (state == S_CLASS))
    else $error("last byte not followed by classify");
endmodule
`default_nettype wire

@@ src/pts_dp.sv @@
// Datapath: header store, counters, size statistics, port tables and read results.
`timescale 1ns / 1ps
`default_nettype none
module pts_dp
  import pts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire pts_cmd_t cmd,
  output pts_stat_t stat,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_byte,
  input  wire logic [4:0] in_sel,
  input  wire logic [5:0] in_idx,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic out_take,
  output logic out_valid,
  output logic [47:0] out_stat,
  output logic [15:0] out_port,
  output logic [31:0] out_count,
  output logic out_entry_valid
);
  logic [15:0] dns_port, http_port, https_port;
  logic [7:0] hdr [HdrBytes];
  logic [10:0] pos;
  logic [31:0] cnt [NumCounters];
  logic [16:0] min_size, max_size;
  logic [47:0] size_sum;

  // Port tables: memories with a valid bit per entry.
  logic [15:0] udp_port_mem [PortEntries];
  logic [31:0] udp_cnt_mem [PortEntries];
  logic [15:0] tcp_port_mem [PortEntries];
  logic [31:0] tcp_cnt_mem [PortEntries];
  logic [PortEntries-1:0] udp_vld, tcp_vld;
  logic [UsedW-1:0] udp_used, tcp_used;

  // Latched frame facts for the port searches.
  logic is_tcp;
  logic [15:0] sp, dp;
  logic [UsedW-1:0] scan_i;
  logic scan_busy;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Header field decode.
  logic [15:0] etype, ip4_len, ip6_len, arp_op;
  logic [7:0] proto, l4_type;
  logic [15:0] l4_sp, l4_dp;
  logic v4, v6, arp;
  logic is_udp_c, is_tcp_c;
  logic [16:0] size;
  always_comb begin
    etype = {hdr[12], hdr[13]};
    ip4_len = {hdr[16], hdr[17]};
    ip6_len = {hdr[18], hdr[19]};
    arp_op = {hdr[20], hdr[21]};
    v4 = etype == 16'h0800;
    arp = etype == 16'h0806;
    v6 = etype == 16'h86DD;
    proto = v4 ? hdr[23] : hdr[20];
    l4_sp = v4 ? {hdr[34], hdr[35]} : {hdr[54], hdr[55]};
    l4_dp = v4 ? {hdr[36], hdr[37]} : {hdr[56], hdr[57]};
    l4_type = v4 ? hdr[34] : hdr[54];
    is_udp_c = (v4 || v6) && proto == 8'd17;
    is_tcp_c = (v4 || v6) && proto == 8'd6;
    size = 17'd14;
    if (v4) size = 17'd14 + {1'b0, ip4_len};
    else if (arp) size = 17'd42;
    else if (v6) size = 17'd54 + {1'b0, ip6_len};
  end

  assign stat.has_ports = is_udp_c || is_tcp_c;

  // Search step: one entry compared per cycle against registered table data.
  logic [15:0] key;
  logic [IdxW-1:0] si, rd_addr;
  logic [UsedW-1:0] used_cur;
  logic hit, at_end, tab_we;
  logic [15:0] udp_rd_port, tcp_rd_port;
  logic [31:0] udp_rd_cnt, tcp_rd_cnt, cnt_cur, cnt_wr;
  always_comb begin
    key = cmd.port_sel ? dp : sp;
    si = scan_i[IdxW-1:0];
    used_cur = is_tcp ? tcp_used : udp_used;
    hit = is_tcp ? (tcp_vld[si] && tcp_rd_port == key)
                 : (udp_vld[si] && udp_rd_port == key);
    at_end = scan_i >= used_cur;
    cnt_cur = is_tcp ? tcp_rd_cnt : udp_rd_cnt;
    cnt_wr = hit ? sat_inc(cnt_cur) : 32'd1;
    tab_we = cmd.scan_step && scan_busy &&
             (hit || (at_end && used_cur != UsedW'(PortEntries)));
    // The next entry to compare is fetched in the cycle before its comparison.
    if (cmd.scan_start) rd_addr = '0;
    else if (cmd.scan_step && scan_busy && !hit && !at_end) rd_addr = si + IdxW'(1);
    else rd_addr = si;
  end
  assign stat.scan_done = cmd.scan_step && scan_busy && (at_end || hit);

  // Header capture and clearing.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_hdr) begin
      for (int i = 0; i < HdrBytes; i++) hdr[i] <= 8'd0;
      pos <= 11'd0;
    end else if (cmd.store_byte) begin
      if (pos < 11'(HdrBytes)) hdr[pos[HposW-1:0]] <= in_byte;
      if (pos != 11'd2047) pos <= pos + 11'd1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dns_port <= 16'd53;
      http_port <= 16'd80;
      https_port <= 16'd443;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DNS: dns_port <= cfg_data;
        REG_HTTP: http_port <= cfg_data;
        REG_HTTPS: https_port <= cfg_data;
        default: ;
      endcase
    end
  end

  // Counters and size statistics, updated on classify.
  logic [48:0] sum_w;
  assign sum_w = {1'b0, size_sum} + 49'(size);
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCounters; i++) cnt[i] <= 32'd0;
      min_size <= SizeReset;
      max_size <= 17'd0;
      size_sum <= 48'd0;
    end else if (cmd.classify) begin
      if (v4) begin
        cnt[C_IPV4] <= sat_inc(cnt[C_IPV4]);
        if (proto == 8'd1) begin
          if (l4_type == 8'd0) cnt[C_ICMP_REP] <= sat_inc(cnt[C_ICMP_REP]);
          else if (l4_type == 8'd8) cnt[C_ICMP_REQ] <= sat_inc(cnt[C_ICMP_REQ]);
        end
      end
      if (arp) begin
        if (arp_op == 16'd1) cnt[C_ARP_REQ] <= sat_inc(cnt[C_ARP_REQ]);
        else if (arp_op == 16'd2) cnt[C_ARP_REP] <= sat_inc(cnt[C_ARP_REP]);
      end
      if (v6) begin
        cnt[C_IPV6] <= sat_inc(cnt[C_IPV6]);
        if (proto == 8'd58) begin
          if (l4_type == 8'd129) cnt[C_ICMP6_REP] <= sat_inc(cnt[C_ICMP6_REP]);
          else if (l4_type == 8'd128) cnt[C_ICMP6_REQ] <= sat_inc(cnt[C_ICMP6_REQ]);
        end
      end
      if (is_udp_c) begin
        cnt[C_UDP] <= sat_inc(cnt[C_UDP]);
        if (l4_dp == dns_port || l4_sp == dns_port) cnt[C_DNS] <= sat_inc(cnt[C_DNS]);
      end
      if (is_tcp_c) begin
        cnt[C_TCP] <= sat_inc(cnt[C_TCP]);
        if (l4_dp == http_port || l4_sp == http_port)
          cnt[C_HTTP] <= sat_inc(cnt[C_HTTP]);
        else if (l4_dp == dns_port || l4_sp == dns_port)
          cnt[C_DNS] <= sat_inc(cnt[C_DNS]);
        else if (l4_dp == https_port || l4_sp == https_port)
          cnt[C_HTTPS] <= sat_inc(cnt[C_HTTPS]);
      end
      if (size > 17'd14) begin
        cnt[C_FRAMES] <= sat_inc(cnt[C_FRAMES]);
        size_sum <= sum_w[48] ? 48'hFFFF_FFFF_FFFF : sum_w[47:0];
        if (size < min_size) min_size <= size;
        if (size > max_size) max_size <= size;
      end
    end
  end

  // Port search control and table updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      udp_vld <= '0;
      tcp_vld <= '0;
      udp_used <= '0;
      tcp_used <= '0;
      scan_busy <= 1'b0;
      scan_i <= '0;
    end else begin
      if (cmd.scan_step && scan_busy) begin
        if (hit) begin
          scan_busy <= 1'b0;
        end else if (at_end) begin
          scan_busy <= 1'b0;
          if (used_cur != UsedW'(PortEntries)) begin
            if (is_tcp) begin
              tcp_vld[si] <= 1'b1;
              tcp_used <= tcp_used + 1'b1;
            end else begin
              udp_vld[si] <= 1'b1;
              udp_used <= udp_used + 1'b1;
            end
          end
        end else begin
          scan_i <= scan_i + 1'b1;
        end
      end
      if (cmd.scan_start) begin
        scan_busy <= 1'b1;
        scan_i <= '0;
      end
    end
  end

  // Table memory writes, registered search reads and latched ports.
  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      is_tcp <= is_tcp_c;
      sp <= l4_sp;
      dp <= l4_dp;
    end
    if (tab_we) begin
      if (is_tcp) begin
        tcp_port_mem[si] <= key;
        tcp_cnt_mem[si] <= cnt_wr;
      end else begin
        udp_port_mem[si] <= key;
        udp_cnt_mem[si] <= cnt_wr;
      end
    end
    // A write to the entry being fetched is passed straight through.
    if (tab_we && !is_tcp && si == rd_addr) begin
      udp_rd_port <= key;
      udp_rd_cnt <= cnt_wr;
    end else begin
      udp_rd_port <= udp_port_mem[rd_addr];
      udp_rd_cnt <= udp_cnt_mem[rd_addr];
    end
    if (tab_we && is_tcp && si == rd_addr) begin
      tcp_rd_port <= key;
      tcp_rd_cnt <= cnt_wr;
    end else begin
      tcp_rd_port <= tcp_port_mem[rd_addr];
      tcp_rd_cnt <= tcp_cnt_mem[rd_addr];
    end
  end

  // Read results in an output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.read_req) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_req) begin
      out_stat <= '0;
      out_port <= '0;
      out_count <= '0;
      out_entry_valid <= 1'b0;
      if (in_func == FUNC_STAT) begin
        if (in_sel < 5'(NumCounters)) out_stat <= {16'd0, cnt[in_sel[3:0]]};
        else if (in_sel == SEL_MIN) out_stat <= {31'd0, min_size};
        else if (in_sel == SEL_MAX) out_stat <= {31'd0, max_size};
        else if (in_sel == SEL_SUM) out_stat <= size_sum;
      end else if (in_func == FUNC_UDP) begin
        if (udp_vld[in_idx[IdxW-1:0]]) begin
          out_port <= udp_port_mem[in_idx[IdxW-1:0]];
          out_count <= udp_cnt_mem[in_idx[IdxW-1:0]];
          out_entry_valid <= 1'b1;
        end
      end else begin
        if (tcp_vld[in_idx[IdxW-1:0]]) begin
          out_port <= tcp_port_mem[in_idx[IdxW-1:0]];
          out_count <= tcp_cnt_mem[in_idx[IdxW-1:0]];
          out_entry_valid <= 1'b1;
        end
      end
    end
  end

  // UDP table fill never exceeds the number of entries.
  a_udp_used: assert property (@(posedge clk) disable iff (rst)
    udp_used <= UsedW'(PortEntries)) else $error("udp table overfilled");
  // The size minimum never exceeds the maximum once a frame is counted.
  a_minmax: assert property (@(posedge clk) disable iff (rst)
    (cnt[C_FRAMES] != 32'd0) |-> (min_size <= max_size || max_size > SizeReset))
    else $error("size bounds inconsistent");
  // A read never arrives while a result is still pending.
  a_read: assert property (@(posedge clk) disable iff (rst)
    cmd.read_req |-> (!out_valid || out_take)) else $error("result overwritten");
endmodule
`default_nettype wire

@@ src/packet_traffic_statistics.sv @@
// Top level: packet classifier and traffic statistics with register port.
//
// Channel  Dir  Payload
// in       in   func, data_byte, last_byte, stat_select, entry_index
// out      out  stat_value, entry_port, entry_count, entry_valid
// cfg      in   index, data (dns_port, http_port, https_port)
//
// Frame bytes are stored while the block is idle; the last byte leads to a classify step and,
// for UDP or TCP, to two table searches, for the source port and then the destination port.
// A read result is registered; any item waits while a result is pending in the output register.
// Reset is synchronous; counters clear at once, tables are marked empty by valid bits.
`timescale 1ns / 1ps
`default_nettype none
module packet_traffic_statistics
  import pts_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  pts_in_if.sink in,
  pts_out_if.source out,
  pts_cfg_if.sink cfg
);
  pts_cmd_t cmd;
  pts_stat_t stat;
  logic in_fire;

  assign in_fire = in.valid && in.ready;
  assign cfg.ready = 1'b1;

  pts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_func(in.func),
    .in_last(in.last_byte), .out_busy(out.valid), .stat(stat),
    .in_ready(in.ready), .cmd(cmd)
  );

  pts_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_func(in.func), .in_byte(in.data_byte), .in_sel(in.stat_select),
    .in_idx(in.entry_index), .cfg_we(cfg.valid), .cfg_index(cfg.index),
    .cfg_data(cfg.data), .out_take(out.ready), .out_valid(out.valid),
    .out_stat(out.stat_value), .out_port(out.entry_port),
    .out_count(out.entry_count), .out_entry_valid(out.entry_valid)
  );
endmodule
`default_nettype wire
